@@ design/rv32sc_pkg.sv @@
// ----------------------------------------------------------------------------
// rv32sc_pkg
// shared constants, instruction codes and the execute result record
// ----------------------------------------------------------------------------
package rv32sc_pkg;

  localparam int unsigned DMEM_BYTES_DEF = 4096;
  localparam int unsigned XLEN           = 32;
  localparam int unsigned NREGS          = 32;
  localparam int unsigned OUT_DATA_W     = 72;
  localparam int unsigned OUT_USER_W     = 3;

  // major opcodes
  localparam logic [6:0] OP_HALT   = 7'h00;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JAL    = 7'h6F;

  // funct3 codes
  localparam logic [2:0] F3_ADD  = 3'h0;
  localparam logic [2:0] F3_XOR  = 3'h4;
  localparam logic [2:0] F3_OR   = 3'h6;
  localparam logic [2:0] F3_SR   = 3'h5;
  localparam logic [2:0] F3_BYTE = 3'h0;
  localparam logic [2:0] F3_WORD = 3'h2;
  localparam logic [2:0] F3_BEQ  = 3'h0;

  // funct7 codes
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [31:0] LUI_MASK = 32'hFFFFF000;

  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        halt;
    logic        bad;
    logic        load;
    logic        store;
    logic        word;
    logic [31:0] addr;
    logic [31:0] sdata;
  } exec_t;

endpackage

@@ design/rv32sc_ram.sv @@
// ----------------------------------------------------------------------------
// rv32sc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module rv32sc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rv32sc_regfile.sv @@
// ----------------------------------------------------------------------------
// rv32sc_regfile
// 32 x 32 register file, two ram copies for two read ports, written bits
// ----------------------------------------------------------------------------
module rv32sc_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rs1,
  input  logic [4:0]  rs2,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  output logic [31:0] rdata1,
  output logic [31:0] rdata2
);
  import rv32sc_pkg::*;

  logic [NREGS-1:0] written;
  logic             ok1;
  logic             ok2;
  logic [XLEN-1:0]  q1;
  logic [XLEN-1:0]  q2;

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      ok1     <= 1'b0;
      ok2     <= 1'b0;
    end else begin
      if (we) begin
        written[wa] <= 1'b1;
      end
      if (rd_en) begin
        ok1 <= written[rs1];
        ok2 <= written[rs2];
      end
    end
  end

  rv32sc_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_copy_a (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (wd),
    .re    (rd_en),
    .raddr (rs1),
    .rdata (q1)
  );

  rv32sc_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_copy_b (
    .clk   (clk),
    .we    (we),
    .waddr (wa),
    .wdata (wd),
    .re    (rd_en),
    .raddr (rs2),
    .rdata (q2)
  );

  assign rdata1 = ok1 ? q1 : '0;
  assign rdata2 = ok2 ? q2 : '0;

endmodule

@@ design/rv32sc_dmem.sv @@
// ----------------------------------------------------------------------------
// rv32sc_dmem
// byte data memory in four byte banks, wrapping word access, clear sweep
// ----------------------------------------------------------------------------
module rv32sc_dmem #(
  parameter int unsigned DMEM_BYTES = rv32sc_pkg::DMEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic        st_en,
  input  logic        word,
  input  logic [31:0] addr,
  input  logic [31:0] sdata,
  output logic        busy,
  output logic [31:0] ld_data
);
  import rv32sc_pkg::*;

  // byte count is a power of two, at least 16
  localparam int unsigned AW   = $clog2(DMEM_BYTES);
  localparam int unsigned ROWS = DMEM_BYTES / 4;
  localparam int unsigned RW   = AW - 2;

  logic [AW-1:0] base;
  logic [RW-1:0] clr_row;
  logic [1:0]    lane0;
  logic [7:0]    bank_q [4];

  assign base = addr[AW-1:0];

  // clear sweep, one row of all four banks per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == RW'(ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      lane0 <= base[1:0];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]    lane;
    logic [AW-1:0] baddr;
    logic          wen;
    logic [RW-1:0] wrow;
    logic [7:0]    wbyte;

    // which byte of the word lands in this bank, and at which byte address
    assign lane  = 2'(j) - base[1:0];
    assign baddr = base + AW'(lane);
    assign wen   = busy || (st_en && (word || lane == 2'd0));
    assign wrow  = busy ? clr_row : baddr[AW-1:2];
    assign wbyte = busy ? 8'h00 : sdata[{lane, 3'b000} +: 8];

    rv32sc_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk   (clk),
      .we    (wen),
      .waddr (wrow),
      .wdata (wbyte),
      .re    (rd_en),
      .raddr (baddr[AW-1:2]),
      .rdata (bank_q[j])
    );
  end

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign ld_data[8*i +: 8] = bank_q[2'(i) + lane0];
  end

endmodule

@@ design/rv32sc_exec.sv @@
// ----------------------------------------------------------------------------
// rv32sc_exec
// decode and execute of one instruction: alu, immediates, next pc, addresses
// ----------------------------------------------------------------------------
module rv32sc_exec (
  input  logic [31:0]        instr,
  input  logic [31:0]        pc,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output rv32sc_pkg::exec_t  res
);
  import rv32sc_pkg::*;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi;
  logic [31:0] imms;
  logic [31:0] immb;
  logic [31:0] immj;
  logic [31:0] pc_inc;

  assign op     = instr[6:0];
  assign f3     = instr[14:12];
  assign f7     = instr[31:25];
  assign immi   = {{20{instr[31]}}, instr[31:20]};
  assign imms   = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign immb   = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign immj   = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign pc_inc = pc + 32'd4;

  always_comb begin
    res       = '0;
    res.npc   = pc_inc;
    res.rd    = instr[11:7];
    res.word  = (f3 == F3_WORD);
    res.addr  = a + immi;
    res.sdata = b;
    case (op)
      OP_HALT: begin
        res.halt = 1'b1;
      end
      OP_REG: begin
        if (f7 == F7_BASE && f3 == F3_ADD) begin
          res.val = a + b;
          res.wr  = 1'b1;
        end else if (f7 == F7_BASE && f3 == F3_XOR) begin
          res.val = a ^ b;
          res.wr  = 1'b1;
        end else begin
          res.bad = 1'b1;
        end
      end
      OP_IMM: begin
        case (f3)
          F3_ADD: begin
            res.val = a + immi;
            res.wr  = 1'b1;
          end
          F3_XOR: begin
            res.val = a ^ immi;
            res.wr  = 1'b1;
          end
          F3_OR: begin
            res.val = a | immi;
            res.wr  = 1'b1;
          end
          F3_SR: begin
            if (f7 == F7_ALT) begin
              res.val = $unsigned($signed(a) >>> instr[24:20]);
              res.wr  = 1'b1;
            end else begin
              res.bad = 1'b1;
            end
          end
          default: begin
            res.bad = 1'b1;
          end
        endcase
      end
      OP_LUI: begin
        res.val = instr & LUI_MASK;
        res.wr  = 1'b1;
      end
      OP_LOAD: begin
        if (f3 == F3_BYTE || f3 == F3_WORD) begin
          res.load = 1'b1;
          res.wr   = 1'b1;
        end else begin
          res.bad = 1'b1;
        end
      end
      OP_STORE: begin
        res.addr = a + imms;
        if (f3 == F3_BYTE || f3 == F3_WORD) begin
          res.store = 1'b1;
        end else begin
          res.bad = 1'b1;
        end
      end
      OP_BRANCH: begin
        if (f3 == F3_BEQ) begin
          if (a == b) begin
            res.npc = pc + immb;
          end
        end else begin
          res.bad = 1'b1;
        end
      end
      OP_JAL: begin
        res.val = pc_inc;
        res.wr  = 1'b1;
        res.npc = pc + immj;
      end
      default: begin
        res.bad = 1'b1;
      end
    endcase
    // halt and illegal leave all state alone
    if (res.halt || res.bad) begin
      res.npc  = pc;
      res.wr   = 1'b0;
      res.load = 1'b0;
    end
    // x0 stays zero
    if (res.rd == 5'd0) begin
      res.wr = 1'b0;
    end
  end

endmodule

@@ design/rv32i_subset_single_cycle_core_top.sv @@
// ----------------------------------------------------------------------------
// rv32i_subset_single_cycle_core_top
// rv32i subset core: one instruction word in, one retirement record out
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one 32-bit instruction word per item, the word fetched at
//   the current pc. m_axis returns one record per instruction: next pc, the
//   register write (flag, index, value), halted and illegal flags.
//   supported: add, xor, addi, xori, ori, srai, lui, lb, lw, sb, sw, beq, jal.
//   path: execute stage, then memory stage, then output register.
//   throughput: one item per cycle, back to back, unless stalled by the
//   output or the memory clear; register results, loads included, are
//   forwarded to the following instruction.
//   reset: pc and all registers read zero; the data memory is then cleared
//   by a sweep over its DMEM_BYTES/4 rows (1024 at the default size),
//   during which s_axis_tready stays low.
//   a stalled receiver holds the output record and freezes the whole pipe;
//   s_axis_tready drops in the same cycle.
//   DMEM_BYTES must be a power of two of at least 16; addresses wrap on it.
// ----------------------------------------------------------------------------
module rv32i_subset_single_cycle_core_top #(
  parameter int unsigned DMEM_BYTES = rv32sc_pkg::DMEM_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [31:0]                        s_axis_tdata,  // instr_word
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // next_pc [31:0], dest_index [36:32], dest_value [68:37], zero pad [71:69]
  output logic [rv32sc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // reg_written [0], halted [1], illegal [2]
  output logic [rv32sc_pkg::OUT_USER_W-1:0]  m_axis_tuser
);
  import rv32sc_pkg::*;

  // pipeline control: every stage moves together when the output can take
  logic        adv;
  logic        acc;
  logic        busy;

  // execute stage
  logic        s1_valid;
  logic [31:0] s1_instr;
  logic [31:0] pc;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  exec_t       ex;

  // write that landed in the register file at the edge that took the
  // current execute item, so its ram read missed it
  logic        byp_wr;
  logic [4:0]  byp_rd;
  logic [31:0] byp_val;

  // memory stage
  logic        s2_valid;
  exec_t       s2;
  logic [31:0] ld_data;
  logic [31:0] s2_value;
  logic        s2_commit;

  // output register
  logic [31:0] out_npc;
  logic        out_wr;
  logic [4:0]  out_rd;
  logic [31:0] out_val;
  logic        out_halt;
  logic        out_bad;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !busy;
  assign acc           = s_axis_tvalid && s_axis_tready;

  rv32sc_regfile u_regfile (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (adv),
    .rs1    (s_axis_tdata[19:15]),
    .rs2    (s_axis_tdata[24:20]),
    .we     (adv && s2_commit),
    .wa     (s2.rd),
    .wd     (s2_value),
    .rdata1 (rf_a),
    .rdata2 (rf_b)
  );

  // operand forwarding: memory stage first, then the write just retired
  always_comb begin
    if (s2_commit && s2.rd == s1_instr[19:15]) begin
      op_a = s2_value;
    end else if (byp_wr && byp_rd == s1_instr[19:15]) begin
      op_a = byp_val;
    end else begin
      op_a = rf_a;
    end
    if (s2_commit && s2.rd == s1_instr[24:20]) begin
      op_b = s2_value;
    end else if (byp_wr && byp_rd == s1_instr[24:20]) begin
      op_b = byp_val;
    end else begin
      op_b = rf_b;
    end
  end

  rv32sc_exec u_exec (
    .instr (s1_instr),
    .pc    (pc),
    .a     (op_a),
    .b     (op_b),
    .res   (ex)
  );

  // loads read and stores write as the item leaves the execute stage
  rv32sc_dmem #(.DMEM_BYTES(DMEM_BYTES)) u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv),
    .st_en   (adv && s1_valid && ex.store),
    .word    (ex.word),
    .addr    (ex.addr),
    .sdata   (ex.sdata),
    .busy    (busy),
    .ld_data (ld_data)
  );

  // load result: lb sign extends the first byte, lw takes all four
  always_comb begin
    if (s2.load) begin
      s2_value = s2.word ? ld_data : {{24{ld_data[7]}}, ld_data[7:0]};
    end else begin
      s2_value = s2.val;
    end
  end

  assign s2_commit = s2_valid && s2.wr;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      byp_wr        <= 1'b0;
      pc            <= '0;
    end else if (adv) begin
      s1_valid      <= acc;
      s2_valid      <= s1_valid;
      m_axis_tvalid <= s2_valid;
      byp_wr        <= s2_commit;
      if (s1_valid) begin
        pc <= ex.npc;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_instr <= s_axis_tdata;
      s2       <= ex;
      byp_rd   <= s2.rd;
      byp_val  <= s2_value;
      out_npc  <= s2.npc;
      out_wr   <= s2.wr;
      out_rd   <= s2.wr ? s2.rd : 5'd0;
      out_val  <= s2.wr ? s2_value : 32'd0;
      out_halt <= s2.halt;
      out_bad  <= s2.bad;
    end
  end

  assign m_axis_tdata = {3'b000, out_val, out_rd, out_npc};
  assign m_axis_tuser = {out_bad, out_halt, out_wr};

  // no item is taken while the data memory is being cleared
  a_no_accept_in_clear : assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_axis_tready)
    else $error("item accepted during memory clear");

  // x0 is never written
  a_no_x0_write : assert property (@(posedge clk) disable iff (rst)
    (adv && s2_commit) |-> (s2.rd != 5'd0))
    else $error("register file write to x0");

  // halt and illegal leave the pc alone
  a_pc_hold : assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && (ex.halt || ex.bad)) |=> (pc == $past(pc)))
    else $error("pc moved on halt or illegal");

  // a record with no register write carries zero index and value
  a_quiet_dest : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[36:32] == 5'd0 && m_axis_tdata[68:37] == 32'd0))
    else $error("destination fields set without a write");

endmodule

@@ test/rv32i_subset_single_cycle_core_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i_subset_single_cycle_core_top_tb
// streams instruction words into the core and checks every retirement record
// against an in-bench model of the architectural state (pc, registers, data
// memory), with random gaps on the input and random stalls on the output
// ----------------------------------------------------------------------------
module rv32i_subset_single_cycle_core_top_tb;
  import rv32sc_pkg::*;

  localparam int unsigned DMEM_BYTES  = DMEM_BYTES_DEF;
  localparam int unsigned N_WORDS     = 1300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_MAX  = 10;

  // one retirement record as the core reports it
  typedef struct packed {
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        halt;
    logic        bad;
  } retire_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // architectural state mirrored by the predictor
  logic [31:0] arch_pc;
  logic [31:0] gpr [NREGS];
  logic [7:0]  dmem [DMEM_BYTES];

  logic [31:0] instr_q [$];   // words waiting to be driven
  retire_t     retire_q [$];  // records the core still owes us

  int unsigned cycle_cnt = 0;
  int unsigned n_issue   = 0;
  int unsigned n_sent    = 0;
  int unsigned n_done    = 0;
  int unsigned n_err     = 0;
  int unsigned n_wr      = 0;
  int unsigned n_load    = 0;
  int unsigned n_store   = 0;
  int unsigned n_redir   = 0;
  int unsigned n_halt    = 0;
  int unsigned n_bad     = 0;

  logic        in_fire  = 1'b0;
  int unsigned in_gap   = 0;
  int unsigned out_stall = 0;
  logic        calm_in  = 1'b0;
  logic        calm_out = 1'b0;

  rv32i_subset_single_cycle_core_top #(
    .DMEM_BYTES(DMEM_BYTES)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // instr_word
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // next_pc, dest_index, dest_value, pad
    .m_axis_tuser (m_axis_tuser)    // reg_written, halted, illegal
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2,
                                        logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd,
                                        logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2,
                                        logic [4:0] rs1, logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2,
                                        logic [4:0] rs1, logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd);
    return {imm, rd, OP_LUI};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // appends one word to the pending input queue
  task automatic enqueue_word(input logic [31:0] w);
    instr_q.insert(instr_q.size(), w);
  endtask

  // ------------------------------------------------------------- stimulus
  // mostly x0..x7 so that results feed the next few instructions
  function automatic logic [4:0] pick_reg();
    logic [31:0] r;
    r = $urandom;
    if (r[31:30] != 2'b00) return {2'b00, r[2:0]};
    return r[4:0];
  endfunction

  function automatic logic [31:0] rand_instr();
    int unsigned sel;
    logic [4:0]  rd, rs1, rs2;
    logic [31:0] w, bits;
    logic [11:0] imm;
    logic [6:0]  opc;
    sel  = $urandom_range(0, 99);
    rd   = pick_reg();
    rs1  = pick_reg();
    rs2  = pick_reg();
    w    = $urandom;
    bits = $urandom;
    imm  = bits[11:0];
    // loads and stores often hit a small window so data comes back
    if (sel >= 50 && sel < 68 && w[31]) begin
      rs1 = 5'd0;
      imm = {6'd0, bits[5:0]};
    end
    if (sel < 8)   return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd);
    if (sel < 14)  return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd);
    if (sel < 24)  return enc_i(imm, rs1, F3_ADD, rd, OP_IMM);
    if (sel < 30)  return enc_i(imm, rs1, F3_XOR, rd, OP_IMM);
    if (sel < 36)  return enc_i(imm, rs1, F3_OR, rd, OP_IMM);
    if (sel < 42)  return enc_i({F7_ALT, bits[4:0]}, rs1, F3_SR, rd, OP_IMM);
    if (sel < 50)  return enc_u(bits[31:12], rd);
    if (sel < 54)  return enc_i(imm, rs1, F3_BYTE, rd, OP_LOAD);
    if (sel < 58)  return enc_i(imm, rs1, F3_WORD, rd, OP_LOAD);
    if (sel < 62)  return enc_s(imm, rs2, rs1, F3_BYTE);
    if (sel < 68)  return enc_s(imm, rs2, rs1, F3_WORD);
    if (sel < 76)  return enc_b({bits[12:1], 1'b0}, w[0] ? rs1 : rs2, rs1, F3_BEQ);
    if (sel < 82)  return enc_j({bits[20:1], 1'b0}, rd);
    if (sel < 84)  return {w[31:7], OP_HALT};
    // random funct fields on a supported opcode, mostly illegal
    if (sel < 90) begin
      case (bits[2:0])
        3'd0:    opc = OP_REG;
        3'd1:    opc = OP_IMM;
        3'd2:    opc = OP_LOAD;
        3'd3:    opc = OP_STORE;
        default: opc = OP_BRANCH;
      endcase
      return {w[31:7], opc};
    end
    return w;
  endfunction

  // ------------------------------------------------------------- predictor
  function automatic int unsigned mem_idx(logic [31:0] a);
    return a % DMEM_BYTES;
  endfunction

  // executes one word on the mirrored state and queues the record it causes
  task automatic execute_instr(input logic [31:0] w);
    logic [6:0]  opc, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, npc, val, ad;
    logic [7:0]  by;
    logic        wr, halt, bad;
    retire_t     rec;
    opc   = w[6:0];
    rd    = w[11:7];
    f3    = w[14:12];
    f7    = w[31:25];
    a     = gpr[w[19:15]];
    b     = gpr[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    npc   = arch_pc + 32'd4;
    val   = '0;
    wr    = 1'b0;
    halt  = 1'b0;
    bad   = 1'b0;
    case (opc)
      OP_HALT: halt = 1'b1;
      OP_REG: begin
        if (f7 == F7_BASE && f3 == F3_ADD) begin
          val = a + b;
          wr  = 1'b1;
        end else if (f7 == F7_BASE && f3 == F3_XOR) begin
          val = a ^ b;
          wr  = 1'b1;
        end else bad = 1'b1;
      end
      OP_IMM: begin
        wr = 1'b1;
        if (f3 == F3_ADD) val = a + imm_i;
        else if (f3 == F3_XOR) val = a ^ imm_i;
        else if (f3 == F3_OR) val = a | imm_i;
        else if (f3 == F3_SR && f7 == F7_ALT) val = $signed(a) >>> w[24:20];
        else begin
          wr  = 1'b0;
          bad = 1'b1;
        end
      end
      OP_LUI: begin
        val = w & LUI_MASK;
        wr  = 1'b1;
      end
      OP_LOAD: begin
        ad = a + imm_i;
        if (f3 == F3_BYTE) begin
          by  = dmem[mem_idx(ad)];
          val = {{24{by[7]}}, by};
          wr  = 1'b1;
          n_load++;
        end else if (f3 == F3_WORD) begin
          // little endian, each byte wraps on its own
          val = {dmem[mem_idx(ad + 32'd3)], dmem[mem_idx(ad + 32'd2)],
                 dmem[mem_idx(ad + 32'd1)], dmem[mem_idx(ad)]};
          wr  = 1'b1;
          n_load++;
        end else bad = 1'b1;
      end
      OP_STORE: begin
        ad = a + imm_s;
        if (f3 == F3_BYTE) begin
          dmem[mem_idx(ad)] = b[7:0];
          n_store++;
        end else if (f3 == F3_WORD) begin
          dmem[mem_idx(ad)]          = b[7:0];
          dmem[mem_idx(ad + 32'd1)]  = b[15:8];
          dmem[mem_idx(ad + 32'd2)]  = b[23:16];
          dmem[mem_idx(ad + 32'd3)]  = b[31:24];
          n_store++;
        end else bad = 1'b1;
      end
      OP_BRANCH: begin
        if (f3 == F3_BEQ) begin
          if (a == b) begin
            npc = arch_pc + imm_b;
            n_redir++;
          end
        end else bad = 1'b1;
      end
      OP_JAL: begin
        val = arch_pc + 32'd4;
        wr  = 1'b1;
        npc = arch_pc + imm_j;
        n_redir++;
      end
      default: bad = 1'b1;
    endcase
    // halt and illegal words leave everything as it was
    if (halt || bad) begin
      npc = arch_pc;
      wr  = 1'b0;
    end
    if (wr && rd == 5'd0) wr = 1'b0;
    if (wr) begin
      gpr[rd] = val;
      n_wr++;
    end else begin
      rd  = '0;
      val = '0;
    end
    if (halt) n_halt++;
    if (bad) n_bad++;
    arch_pc  = npc;
    rec.npc  = npc;
    rec.wr   = wr;
    rec.rd   = rd;
    rec.val  = val;
    rec.halt = halt;
    rec.bad  = bad;
    retire_q.insert(retire_q.size(), rec);
  endtask

  // ---------------------------------------------------------------- driver
  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap(logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // inputs move on the falling edge only
  always @(negedge clk) begin
    if (cycle_cnt[7:0] == 8'd0) calm_in <= ($urandom_range(0, 3) == 0);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap        <= in_gap - 1;
      end else if (instr_q.size() != 0) begin
        s_axis_tdata  <= instr_q.pop_front();
        s_axis_tvalid <= 1'b1;
        in_gap        <= pick_gap(calm_in);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure, with calm stretches of no stalls
  always @(negedge clk) begin
    if (cycle_cnt[7:0] == 8'd0) calm_out <= ($urandom_range(0, 3) == 0);
    if (out_stall != 0) begin
      m_axis_tready <= 1'b0;
      out_stall     <= out_stall - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm_out && $urandom_range(0, 99) < 25) out_stall <= pick_gap(1'b0);
    end
  end

  // --------------------------------------------------------------- monitor
  // both handshakes are sampled on the rising edge
  always @(posedge clk) begin : mon
    retire_t got, want;
    cycle_cnt <= cycle_cnt + 1;
    in_fire   <= s_axis_tvalid && s_axis_tready && !rst;
    if (!rst) begin
      // predict first, so a record can never overtake its own word
      if (s_axis_tvalid && s_axis_tready) begin
        execute_instr(s_axis_tdata);
        n_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.npc  = m_axis_tdata[31:0];
        got.rd   = m_axis_tdata[36:32];
        got.val  = m_axis_tdata[68:37];
        got.wr   = m_axis_tuser[0];
        got.halt = m_axis_tuser[1];
        got.bad  = m_axis_tuser[2];
        if (retire_q.size() == 0) begin
          n_err++;
          if (n_err <= REPORT_MAX)
            $display("[%0d] record with nothing pending: pc=%h wr=%b rd=%0d val=%h",
                     cycle_cnt, got.npc, got.wr, got.rd, got.val);
        end else begin
          want = retire_q.pop_front();
          if (got.npc !== want.npc || got.wr !== want.wr || got.rd !== want.rd ||
              got.val !== want.val || got.halt !== want.halt ||
              got.bad !== want.bad) begin
            n_err++;
            if (n_err <= REPORT_MAX) begin
              $display("[%0d] record %0d mismatch: exp pc=%h wr=%b rd=%0d val=%h halt=%b ill=%b",
                       cycle_cnt, n_done, want.npc, want.wr, want.rd, want.val,
                       want.halt, want.bad);
              $display("    got pc=%h wr=%b rd=%0d val=%h halt=%b ill=%b",
                       got.npc, got.wr, got.rd, got.val, got.halt, got.bad);
            end
          end
          n_done++;
        end
      end
    end
  end

  // ------------------------------------------------------------- watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("rv32i_subset_single_cycle_core_top_tb: errors");
    $finish;
  end

  // ------------------------------------------------------------------ main
  initial begin
    arch_pc = '0;
    for (int i = 0; i < NREGS; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_BYTES; i++) dmem[i] = '0;

    // directed words: field extremes, every instruction, the corner cases
    enqueue_word(32'h0000_0000);                           // halt
    enqueue_word(enc_u(20'hFFFFF, 5'd1));                  // lui top
    enqueue_word(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd2, OP_IMM));   // -1
    enqueue_word(enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OP_IMM));   // max imm
    enqueue_word(enc_i(12'h800, 5'd0, F3_ADD, 5'd4, OP_IMM));   // min imm
    enqueue_word(enc_i(12'h555, 5'd2, F3_XOR, 5'd5, OP_IMM));
    enqueue_word(enc_i(12'h0F0, 5'd4, F3_OR, 5'd6, OP_IMM));
    enqueue_word(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd7, OP_IMM));
    enqueue_word(enc_i({F7_ALT, 5'd0}, 5'd3, F3_SR, 5'd8, OP_IMM)); // shift 0
    enqueue_word(enc_r(F7_BASE, 5'd3, 5'd2, F3_ADD, 5'd9));  // wraps
    enqueue_word(enc_r(F7_BASE, 5'd3, 5'd1, F3_XOR, 5'd10));
    // word store at the top of memory wraps onto address zero
    enqueue_word(enc_s(12'hFFE, 5'd2, 5'd0, F3_WORD));
    enqueue_word(enc_i(12'hFFE, 5'd0, F3_WORD, 5'd11, OP_LOAD));
    enqueue_word(enc_s(12'h008, 5'd3, 5'd0, F3_BYTE));
    enqueue_word(enc_i(12'h008, 5'd0, F3_BYTE, 5'd12, OP_LOAD)); // negative byte
    enqueue_word(enc_i(12'h000, 5'd1, F3_WORD, 5'd13, OP_LOAD)); // far base
    enqueue_word(enc_i(12'h005, 5'd3, F3_ADD, 5'd0, OP_IMM));    // x0 dropped
    enqueue_word(enc_b(13'h1000, 5'd0, 5'd0, F3_BEQ));           // taken, min
    enqueue_word(enc_b(13'h0FFE, 5'd3, 5'd2, F3_BEQ));           // not taken
    enqueue_word(enc_j(21'h100000, 5'd1));                       // jal min
    enqueue_word(enc_j(21'h0FFFFE, 5'd0));                       // jal max, no link
    enqueue_word(enc_r(F7_ALT, 5'd3, 5'd2, F3_ADD, 5'd14));      // bad funct7
    enqueue_word(enc_i({F7_BASE, 5'd3}, 5'd1, F3_SR, 5'd15, OP_IMM)); // bad funct7
    enqueue_word(enc_i(12'h000, 5'd0, 3'd1, 5'd16, OP_LOAD));    // bad width
    enqueue_word(32'hFFFF_FFFF);                                 // unknown opcode
    enqueue_word(32'hFFFF_FF80);                                 // halt, busy fields

    while (instr_q.size() < N_WORDS) enqueue_word(rand_instr());
    n_issue = instr_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the memory clear after reset holds tready low; just wait on handshakes
    while (n_sent < n_issue) @(posedge clk);
    while (retire_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("ran %0d instruction words, %0d records checked: %0d register writes,",
             n_sent, n_done, n_wr);
    $display("  %0d loads, %0d stores, %0d redirects, %0d halts, %0d illegal, %0d errors",
             n_load, n_store, n_redir, n_halt, n_bad, n_err);
    if (n_err == 0) begin
      $display("rv32i_subset_single_cycle_core_top_tb: clean");
    end else begin
      $display("rv32i_subset_single_cycle_core_top_tb: errors");
    end
    $finish;
  end

endmodule
